// ===== rtl/core/piecewise_linear_table_interpolator_macros.svh =====
// Assertion macros shared by the interpolator's controller and datapath.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef PIECEWISE_LINEAR_TABLE_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_LINEAR_TABLE_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PLTI_ASSERT_IMP(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("plti: same-cycle check failed");

// next-cycle implication
`define PLTI_ASSERT_NXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("plti: next-cycle check failed");

`else

`define PLTI_ASSERT_IMP(name, clk_s, rstn_s, ante, cons)
`define PLTI_ASSERT_NXT(name, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/core/plti_pkg.sv =====
// Shared types and constants of the piecewise-linear table interpolator.
// No dependencies; used by the controller, the datapath and the top level.
package plti_pkg;

  // fixed field widths
  localparam int POINT_INDEX_W = 8;
  localparam int PIU_W         = 9;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int MUL_CHUNK_W   = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_IN_USE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSTANT_VALUE = 1'b1;

  // item actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_FIRST,
    S_CHK_FIRST,
    S_RD_LAST,
    S_CHK_LAST,
    S_RD_MID,
    S_CHK_MID,
    S_SETUP,
    S_MUL,
    S_DIV_START,
    S_DIV,
    S_SUM,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ADDR_LO,
    ADDR_HI,
    ADDR_MID
  } addr_sel_t;

  typedef enum logic [1:0] {
    RES_CONST,
    RES_RDATA,
    RES_LOW,
    RES_SUM
  } res_src_t;

  typedef struct packed {
    logic      mem_we;
    logic      load_query;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      take_first;
    logic      take_last;
    logic      take_mid;
    logic      res_load;
    res_src_t  res_src;
    logic      arith_setup;
    logic      mul_step;
    logic      div_start;
    logic      div_step;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic le_first;
    logic ge_last;
    logic bracket_done;
    logic dx_zero;
    logic step_last;
    logic quot_ovf;
  } sts_t;

endpackage

// ===== rtl/core/piecewise_linear_table_interpolator.sv =====
// A write word is taken while idle. A query returns the constant when no points are in use,
// the first or last point's value when clamped there, else runs the bisection (a read, then
// a check, per probe), the chunked multiply and the one-bit-per-cycle restoring divide.
// One item at a time: the input stalls until the query's result is loaded for output.
// Reset (synchronous, rst_n low) clears the sequencer, the output valid and both config
// registers; the breakpoint memory is not cleared and holds garbage until written.
//
// Structure: plti_ctrl sequences each query; plti_dpath holds the breakpoint memory
// (one write or one registered read per cycle), the bracket registers, a 16-bit-chunk
// multiplier and a restoring divider. The result sits in an output register, so the
// next word is taken while the previous result still waits downstream.
// Depends on plti_pkg, plti_ctrl and plti_dpath.

module piecewise_linear_table_interpolator
  import plti_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  // input words
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_action,
  input  logic [POINT_INDEX_W-1:0]       in_point_index,
  input  logic signed [NUMBER_WIDTH-1:0] in_point_coordinate,
  input  logic signed [NUMBER_WIDTH-1:0] in_point_value,
  input  logic signed [NUMBER_WIDTH-1:0] in_query_coordinate,
  // result words
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [NUMBER_WIDTH-1:0] out_result_value
);

  logic [PIU_W-1:0]              points_in_use_r;
  logic [CFG_DATA_W-1:0]         constant_value_r;
  logic                          out_valid_r;
  logic signed [NUMBER_WIDTH-1:0] out_result_value_r;

  cmd_t                          cmd;
  sts_t                          sts;
  logic                          busy;
  logic                          out_free;
  logic signed [NUMBER_WIDTH-1:0] res_value;

  // config registers; written only while idle is the user's duty, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_in_use_r  <= '0;
      constant_value_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINTS_IN_USE:  points_in_use_r  <= cfg_wdata[PIU_W-1:0];
        CFG_CONSTANT_VALUE: constant_value_r <= cfg_wdata;
        default: begin
          points_in_use_r <= points_in_use_r;
        end
      endcase
    end
  end

  // output slot can take a new result if empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload only moves when the slot is free, so a stalled word holds
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_value_r <= res_value;
    end
  end

  plti_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .out_free  (out_free),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  plti_dpath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_point_index      (in_point_index),
    .in_point_coordinate (in_point_coordinate),
    .in_point_value      (in_point_value),
    .in_query_coordinate (in_query_coordinate),
    .cfg_points_in_use   (points_in_use_r),
    .cfg_constant_value  (constant_value_r),
    .cmd                 (cmd),
    .sts                 (sts),
    .res_value           (res_value)
  );

  // input side only listens in the idle state
  assign in_stall         = busy;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_value_r;

endmodule

// ===== rtl/core/plti_ctrl.sv =====
// Query sequencer of the interpolator: one state machine driving the datapath.
// Depends on plti_pkg and the assertion macro header.
`include "piecewise_linear_table_interpolator_macros.svh"

module plti_ctrl
  import plti_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_action,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_action == ACT_QUERY)) begin
          state_nxt = sts.n_zero ? S_DONE : S_RD_FIRST;
        end
      end
      S_RD_FIRST:  state_nxt = S_CHK_FIRST;
      S_CHK_FIRST: state_nxt = sts.le_first ? S_DONE : S_RD_LAST;
      S_RD_LAST:   state_nxt = S_CHK_LAST;
      S_CHK_LAST:  state_nxt = sts.ge_last ? S_DONE : S_RD_MID;
      S_RD_MID:    state_nxt = sts.bracket_done ? S_SETUP : S_CHK_MID;
      S_CHK_MID:   state_nxt = S_RD_MID;
      S_SETUP:     state_nxt = sts.dx_zero ? S_DONE : S_MUL;
      S_MUL:       state_nxt = sts.step_last ? S_DIV_START : S_MUL;
      S_DIV_START: state_nxt = sts.quot_ovf ? S_SUM : S_DIV;
      S_DIV:       state_nxt = sts.step_last ? S_SUM : S_DIV;
      S_SUM:       state_nxt = S_DONE;
      S_DONE:      state_nxt = out_free ? S_IDLE : S_DONE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.rd_sel  = ADDR_LO;
    cmd.res_src = RES_CONST;
    busy        = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_WRITE) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            if (sts.n_zero) begin
              cmd.res_load = 1'b1;
              cmd.res_src  = RES_CONST;
            end
          end
        end
      end
      S_RD_FIRST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_LO;
      end
      S_CHK_FIRST: begin
        cmd.take_first = 1'b1;
        if (sts.le_first) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_RDATA;
        end
      end
      S_RD_LAST: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = ADDR_HI;
      end
      S_CHK_LAST: begin
        cmd.take_last = 1'b1;
        if (sts.ge_last) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_RDATA;
        end
      end
      S_RD_MID: begin
        if (!sts.bracket_done) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_MID;
        end
      end
      S_CHK_MID: cmd.take_mid = 1'b1;
      S_SETUP: begin
        if (sts.dx_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_LOW;
        end else begin
          cmd.arith_setup = 1'b1;
        end
      end
      S_MUL:       cmd.mul_step  = 1'b1;
      S_DIV_START: cmd.div_start = 1'b1;
      S_DIV:       cmd.div_step  = 1'b1;
      S_SUM: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_SUM;
      end
      S_DONE:      cmd.out_load = out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  `PLTI_ASSERT_NXT(a_query_starts, clk, rst_n, (state_r == S_IDLE) && in_valid && (in_action == ACT_QUERY) && !sts.n_zero, state_r == S_RD_FIRST)
  `PLTI_ASSERT_NXT(a_div_to_sum, clk, rst_n, (state_r == S_DIV) && sts.step_last, state_r == S_SUM)
  `PLTI_ASSERT_NXT(a_done_holds, clk, rst_n, (state_r == S_DONE) && !out_free, state_r == S_DONE)

endmodule

// ===== rtl/core/plti_dpath.sv =====
// Datapath of the interpolator: breakpoint memory, bracket registers,
// chunked multiplier and restoring divider. Depends on plti_pkg and the macro header.
`include "piecewise_linear_table_interpolator_macros.svh"

module plti_dpath
  import plti_pkg::*;
#(
  parameter int TABLE_DEPTH  = 256,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [POINT_INDEX_W-1:0]       in_point_index,
  input  logic signed [NUMBER_WIDTH-1:0] in_point_coordinate,
  input  logic signed [NUMBER_WIDTH-1:0] in_point_value,
  input  logic signed [NUMBER_WIDTH-1:0] in_query_coordinate,
  input  logic [PIU_W-1:0]               cfg_points_in_use,
  input  logic [CFG_DATA_W-1:0]          cfg_constant_value,
  input  cmd_t                           cmd,
  output sts_t                           sts,
  output logic signed [NUMBER_WIDTH-1:0] res_value
);

  localparam int NW        = NUMBER_WIDTH;
  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int QW        = NW + 1;                  // quotient bits before saturation
  localparam int PW        = 2 * NW + 2;              // product width
  localparam int MUL_STEPS = (NW + MUL_CHUNK_W) / MUL_CHUNK_W;
  localparam int BPW       = MUL_STEPS * MUL_CHUNK_W;
  localparam int CW        = $clog2(QW + 1);

  // breakpoint memory: {coordinate, value}
  logic [2*NW-1:0] entry_mem_r [TABLE_DEPTH];
  logic [2*NW-1:0] rd_data_r;

  logic signed [NW-1:0] x_r, x0_r, v0_r, x1_r, v1_r;
  logic [AW-1:0]        i0_r, i1_r;
  logic [NW:0]          a_r;
  logic [BPW-1:0]       b_r;
  logic [NW:0]          den_r;
  logic                 neg_r;
  logic                 ovf_r;
  logic [PW-1:0]        acc_r;
  logic [NW:0]          rem_r;
  logic [QW-1:0]        lo_r;
  logic [CW-1:0]        cnt_r;
  logic signed [NW-1:0] res_r;

  logic [31:0]          idx_ext;
  logic                 wr_ok;
  logic [AW-1:0]        wr_addr;
  logic [31:0]          n_eff;
  logic [31:0]          last_idx;
  logic [AW:0]          isum;
  logic [AW-1:0]        ic;
  logic [AW-1:0]        gap;
  logic [AW-1:0]        rd_addr;
  logic signed [NW-1:0] rd_coord;
  logic signed [NW-1:0] rd_value;
  logic                 go_low;
  logic signed [NW:0]   dv, dx, dxc;
  logic [NW:0]          dv_mag, dx_mag, dxc_mag;
  logic [NW+MUL_CHUNK_W:0] pp;
  logic [PW-1:0]        acc_nxt;
  logic [NW+1:0]        rem2;
  logic [NW+1:0]        rem_diff;
  logic                 q_bit;
  logic [NW:0]          rem_nxt;
  logic signed [NW+2:0] sum_ext;
  logic signed [NW-1:0] sum_sat;
  logic signed [NW-1:0] num_max, num_min;
  logic [63:0]          const_ext;

  // write address; entries past the table are dropped
  assign idx_ext = 32'(in_point_index);
  assign wr_ok   = idx_ext < 32'(TABLE_DEPTH);
  assign wr_addr = idx_ext[AW-1:0];

  assign n_eff    = (32'(cfg_points_in_use) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                                : 32'(cfg_points_in_use);
  assign last_idx = n_eff - 32'd1;

  assign isum = {1'b0, i0_r} + {1'b0, i1_r};
  assign ic   = isum[AW:1];
  assign gap  = i1_r - i0_r;

  always_comb begin
    unique case (cmd.rd_sel)
      ADDR_LO:  rd_addr = i0_r;
      ADDR_HI:  rd_addr = i1_r;
      ADDR_MID: rd_addr = ic;
      default:  rd_addr = i0_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we && wr_ok) begin
      entry_mem_r[wr_addr] <= {in_point_coordinate, in_point_value};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= entry_mem_r[rd_addr];
    end
  end

  assign rd_coord = $signed(rd_data_r[2*NW-1:NW]);
  assign rd_value = $signed(rd_data_r[NW-1:0]);

  // bisection: move the upper end when x sits at or before the midpoint
  assign go_low = (x_r == rd_coord) || (x_r == x0_r) ||
                  ((x_r < rd_coord) != (x_r < x0_r));

  assign dv      = {v1_r[NW-1], v1_r} - {v0_r[NW-1], v0_r};
  assign dx      = {x_r[NW-1], x_r} - {x0_r[NW-1], x0_r};
  assign dxc     = {x1_r[NW-1], x1_r} - {x0_r[NW-1], x0_r};
  assign dv_mag  = dv[NW]  ? 0 - dv  : dv;
  assign dx_mag  = dx[NW]  ? 0 - dx  : dx;
  assign dxc_mag = dxc[NW] ? 0 - dxc : dxc;

  // multiply: one 16-bit chunk of b per cycle, top chunk first
  assign pp      = a_r * b_r[BPW-1 -: MUL_CHUNK_W];
  assign acc_nxt = (acc_r << MUL_CHUNK_W) + PW'(pp);

  // restoring divide, one quotient bit per cycle
  assign rem2     = {rem_r, lo_r[QW-1]};
  assign rem_diff = rem2 - {1'b0, den_r};
  assign q_bit    = rem2 >= {1'b0, den_r};
  assign rem_nxt  = q_bit ? rem_diff[NW:0] : rem2[NW:0];

  assign num_max = {1'b0, {(NW-1){1'b1}}};
  assign num_min = {1'b1, {(NW-1){1'b0}}};

  assign sum_ext = neg_r ? (NW+3)'(v0_r) - $signed({2'b00, lo_r})
                         : (NW+3)'(v0_r) + $signed({2'b00, lo_r});

  always_comb begin
    if (ovf_r) begin
      sum_sat = neg_r ? num_min : num_max;
    end else if (sum_ext > (NW+3)'(num_max)) begin
      sum_sat = num_max;
    end else if (sum_ext < (NW+3)'(num_min)) begin
      sum_sat = num_min;
    end else begin
      sum_sat = sum_ext[NW-1:0];
    end
  end

  // constant register is zero-extended then cut to the number width
  assign const_ext = 64'(cfg_constant_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.arith_setup) begin
      cnt_r <= CW'(MUL_STEPS);
    end else if (cmd.div_start) begin
      cnt_r <= CW'(QW);
    end else if (cmd.mul_step || cmd.div_step) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      x_r  <= in_query_coordinate;
      i0_r <= '0;
      i1_r <= last_idx[AW-1:0];
    end
    if (cmd.take_first) begin
      x0_r <= rd_coord;
      v0_r <= rd_value;
    end
    if (cmd.take_last) begin
      x1_r <= rd_coord;
      v1_r <= rd_value;
    end
    if (cmd.take_mid) begin
      if (go_low) begin
        i1_r <= ic;
        x1_r <= rd_coord;
        v1_r <= rd_value;
      end else begin
        i0_r <= ic;
        x0_r <= rd_coord;
        v0_r <= rd_value;
      end
    end
    if (cmd.arith_setup) begin
      a_r   <= dv_mag;
      b_r   <= BPW'(dx_mag);
      den_r <= dxc_mag;
      neg_r <= dv[NW] ^ dx[NW] ^ dxc[NW];
      acc_r <= '0;
    end
    if (cmd.mul_step) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << MUL_CHUNK_W;
    end
    if (cmd.div_start) begin
      rem_r <= acc_r[PW-1:QW];
      lo_r  <= acc_r[QW-1:0];
      ovf_r <= sts.quot_ovf;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[QW-2:0], q_bit};
    end
    if (cmd.res_load) begin
      unique case (cmd.res_src)
        RES_CONST: res_r <= const_ext[NW-1:0];
        RES_RDATA: res_r <= rd_value;
        RES_LOW:   res_r <= v0_r;
        RES_SUM:   res_r <= sum_sat;
        default:   res_r <= v0_r;
      endcase
    end
  end

  assign sts.n_zero       = (cfg_points_in_use == '0);
  assign sts.le_first     = (x_r <= rd_coord);
  assign sts.ge_last      = (x_r >= rd_coord);
  assign sts.bracket_done = (gap <= AW'(1));
  assign sts.dx_zero      = (x1_r == x0_r);
  assign sts.step_last    = (cnt_r == CW'(1));
  // quotient would need more than QW bits: the sum saturates for sure
  assign sts.quot_ovf     = (acc_r[PW-1:QW] >= den_r);

  assign res_value = res_r;

  `PLTI_ASSERT_IMP(a_mid_inside, clk, rst_n, cmd.take_mid, (ic > i0_r) && (ic < i1_r))
  `PLTI_ASSERT_NXT(a_rem_after_start, clk, rst_n, cmd.div_start && !sts.quot_ovf, rem_r < den_r)
  `PLTI_ASSERT_NXT(a_rem_in_range, clk, rst_n, cmd.div_step, rem_r < den_r)

endmodule
